>>> rtl/core/hysteresis_noise_gate_unit_macros.svh
// Assertion macros used by the noise gate checker
`ifndef HYSTERESIS_NOISE_GATE_UNIT_MACROS_SVH
`define HYSTERESIS_NOISE_GATE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HNG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication, sampled on clk, off during reset
`define HNG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

>>> rtl/core/hng_pkg.sv
// Package: widths, constants and register codes of the noise gate
`default_nettype none
package hng_pkg;
	localparam int CHANNELS   = 2;
	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 24;
	localparam int GAIN_W     = 25;
	localparam int OP_W       = 26;
	localparam int PROD_W     = 2 * OP_W;
	localparam int FRAC_W     = 24;
	localparam int SUM_W      = PROD_W - FRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int TDATA_W    = 2 * SAMPLE_W;

	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [GAIN_W-1:0]        gain_t;
	typedef logic [SAMPLE_W-1:0]      env_t;
	typedef logic [COEF_W-1:0]        coef_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam gain_t GAIN_UNITY = gain_t'(25'd16777216);

	localparam cfg_idx_t REG_OPEN_TH   = 3'd0;
	localparam cfg_idx_t REG_CLOSE_TH  = 3'd1;
	localparam cfg_idx_t REG_ENV_ATK   = 3'd2;
	localparam cfg_idx_t REG_ENV_REL   = 3'd3;
	localparam cfg_idx_t REG_GATE_OPEN = 3'd4;
	localparam cfg_idx_t REG_GATE_CLS  = 3'd5;

	localparam coef_t RST_OPEN_TH   = 24'd8389;
	localparam coef_t RST_CLOSE_TH  = 24'd2517;
	localparam coef_t RST_ENV_ATK   = 24'd16707456;
	localparam coef_t RST_ENV_REL   = 24'd16770227;
	localparam coef_t RST_GATE_OPEN = 24'd16603355;
	localparam coef_t RST_GATE_CLS  = 24'd16772847;

	localparam sum_t SAT_MAX = sum_t'(28'sd8388607);
	localparam sum_t SAT_MIN = -sum_t'(28'sd8388608);
endpackage
`default_nettype wire

>>> rtl/core/hng_mac.sv
// Shared signed multiplier with registered product
`default_nettype none
module hng_mac (
	input  wire logic          clk,
	input  wire hng_pkg::op_t  opa,
	input  wire hng_pkg::op_t  opb,
	output hng_pkg::prod_t     prod_s1
);
	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
	end
endmodule
`default_nettype wire

>>> rtl/core/hysteresis_noise_gate_unit.sv
// Top level: per-channel noise gate with hysteresis on a shared multiplier
// Flow: an accepted word steps through MUL_ENV, UPD_ENV, MUL_GAIN, UPD_GAIN,
// MUL_OUT and FINISH (three passes through the single 26x26 multiplier, each
// followed by an update step); a new word is taken only once back in IDLE.
// Reset: arst_n clears control state and loads register defaults; envelopes
// reset to zero and gains to unity.
`default_nettype none
module hysteresis_noise_gate_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [hng_pkg::TDATA_W-1:0]   s_tdata,  // detect_sample, signal_sample
	input  wire logic                          s_tuser,  // channel
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [hng_pkg::SAMPLE_W-1:0]       m_tdata,  // gated_sample
	input  wire logic                          cfg_we,
	input  wire hng_pkg::cfg_idx_t             cfg_index,
	input  wire hng_pkg::coef_t                cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_ENV,
		ST_UPD_ENV,
		ST_MUL_GAIN,
		ST_UPD_GAIN,
		ST_MUL_OUT,
		ST_FINISH
	} state_t;

	state_t              state_q;
	hng_pkg::coef_t      open_th_q, close_th_q, env_atk_q, env_rel_q, gate_open_q, gate_cls_q;
	hng_pkg::env_t       env_q  [hng_pkg::CHANNELS];
	hng_pkg::gain_t      gain_q [hng_pkg::CHANNELS];
	logic                ch_q;
	logic                pass_q;
	logic [hng_pkg::SAMPLE_W-1:0] sig_q;
	hng_pkg::op_t        opa_q, opb_q;
	hng_pkg::gain_t      base_q;
	logic                out_valid_q;
	logic [hng_pkg::SAMPLE_W-1:0] out_q;

	hng_pkg::prod_t      prod_s1;
	hng_pkg::sum_t       prod_sh;
	hng_pkg::sum_t       upd_sum;
	logic signed [hng_pkg::SAMPLE_W-1:0] det_in;
	hng_pkg::env_t       mag_in;
	hng_pkg::env_t       env_cur;
	hng_pkg::env_t       env_new;
	hng_pkg::gain_t      gain_new;
	logic [hng_pkg::SAMPLE_W-1:0] sat_res;
	logic                pass_in;

	hng_mac u_mac (
		.clk     (clk),
		.opa     (opa_q),
		.opb     (opb_q),
		.prod_s1 (prod_s1)
	);

	always_comb begin
		det_in   = s_tdata[hng_pkg::SAMPLE_W-1:0];
		mag_in   = det_in[hng_pkg::SAMPLE_W-1] ? hng_pkg::env_t'(-det_in)
		                                        : hng_pkg::env_t'(det_in);
		pass_in  = (32'(s_tuser) >= hng_pkg::CHANNELS);
		env_cur  = env_q[s_tuser];
		prod_sh  = prod_s1[hng_pkg::PROD_W-1:hng_pkg::FRAC_W];
		upd_sum  = hng_pkg::sum_t'($signed({3'b000, base_q})) + prod_sh;
		env_new  = upd_sum[hng_pkg::SAMPLE_W-1:0];
		gain_new = (upd_sum > hng_pkg::sum_t'($signed({3'b000, hng_pkg::GAIN_UNITY})))
		           ? hng_pkg::GAIN_UNITY : upd_sum[hng_pkg::GAIN_W-1:0];
		if (prod_sh > hng_pkg::SAT_MAX) begin
			sat_res = hng_pkg::SAMPLE_W'(hng_pkg::SAT_MAX);
		end else if (prod_sh < hng_pkg::SAT_MIN) begin
			sat_res = hng_pkg::SAMPLE_W'(hng_pkg::SAT_MIN);
		end else begin
			sat_res = prod_sh[hng_pkg::SAMPLE_W-1:0];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_th_q   <= hng_pkg::RST_OPEN_TH;
			close_th_q  <= hng_pkg::RST_CLOSE_TH;
			env_atk_q   <= hng_pkg::RST_ENV_ATK;
			env_rel_q   <= hng_pkg::RST_ENV_REL;
			gate_open_q <= hng_pkg::RST_GATE_OPEN;
			gate_cls_q  <= hng_pkg::RST_GATE_CLS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hng_pkg::REG_OPEN_TH:   open_th_q   <= cfg_data;
				hng_pkg::REG_CLOSE_TH:  close_th_q  <= cfg_data;
				hng_pkg::REG_ENV_ATK:   env_atk_q   <= cfg_data;
				hng_pkg::REG_ENV_REL:   env_rel_q   <= cfg_data;
				hng_pkg::REG_GATE_OPEN: gate_open_q <= cfg_data;
				hng_pkg::REG_GATE_CLS:  gate_cls_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < hng_pkg::CHANNELS; i++) begin
				env_q[i]  <= '0;
				gain_q[i] <= hng_pkg::GAIN_UNITY;
			end
		end else begin
			if (out_valid_q && m_tready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= pass_in ? ST_FINISH : ST_MUL_ENV;
					end
				end
				ST_MUL_ENV:  state_q <= ST_UPD_ENV;
				ST_UPD_ENV: begin
					env_q[ch_q] <= env_new;
					state_q     <= ST_MUL_GAIN;
				end
				ST_MUL_GAIN: state_q <= ST_UPD_GAIN;
				ST_UPD_GAIN: begin
					gain_q[ch_q] <= gain_new;
					state_q      <= ST_MUL_OUT;
				end
				ST_MUL_OUT:  state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ch_q   <= s_tuser;
					pass_q <= pass_in;
					sig_q  <= s_tdata[hng_pkg::TDATA_W-1:hng_pkg::SAMPLE_W];
					base_q <= hng_pkg::GAIN_W'(mag_in);
					opa_q  <= hng_pkg::op_t'({2'b00, (mag_in > env_cur) ? env_atk_q
					                                                     : env_rel_q});
					opb_q  <= hng_pkg::op_t'({2'b00, env_cur}) - hng_pkg::op_t'({2'b00, mag_in});
				end
			end
			ST_UPD_ENV: begin
				if (env_new < close_th_q) begin
					opa_q  <= hng_pkg::op_t'({2'b00, gate_cls_q});
					opb_q  <= hng_pkg::op_t'({1'b0, gain_q[ch_q]});
					base_q <= '0;
				end else if (env_new > open_th_q) begin
					opa_q  <= hng_pkg::op_t'({2'b00, gate_open_q});
					opb_q  <= hng_pkg::op_t'({1'b0, gain_q[ch_q]})
					          - hng_pkg::op_t'({1'b0, hng_pkg::GAIN_UNITY});
					base_q <= hng_pkg::GAIN_UNITY;
				end else begin
					opa_q  <= '0;
					opb_q  <= '0;
					base_q <= gain_q[ch_q];
				end
			end
			ST_UPD_GAIN: begin
				opa_q <= hng_pkg::op_t'($signed(sig_q));
				opb_q <= hng_pkg::op_t'({1'b0, gain_new});
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_q <= pass_q ? sig_q : sat_res;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/core/hng_checker.sv
// Port checker for the noise gate, bound to the top level
`default_nettype none
`include "hysteresis_noise_gate_unit_macros.svh"
module hng_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [hng_pkg::SAMPLE_W-1:0] m_tdata
);
	`HNG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`HNG_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`HNG_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))
	`HNG_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), !$past(s_tready))
endmodule

bind hysteresis_noise_gate_unit hng_checker u_hng_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
